[hw/rtl/mbps_pkg.sv]
`default_nettype none
package mbps_pkg;

    localparam int MaxPatternBytes = 32;
    localparam int OffsetBits      = 32;
    localparam int MatchOffsetBits = 32;
    localparam int LenBits         = 6;
    localparam int LenIdxBits      = $clog2(MaxPatternBytes);
    localparam int CfgIndexBits    = 3;
    localparam int CfgDataBits     = 64;
    localparam int MaskBits        = 32;
    localparam int FifoDepth       = 2;
    localparam int FifoPtrBits     = $clog2(FifoDepth);
    localparam int FifoCountBits   = $clog2(FifoDepth + 1);

    typedef enum logic [CfgIndexBits-1:0] {
        CFG_PATTERN_0_7   = 3'd0,
        CFG_PATTERN_8_15  = 3'd1,
        CFG_PATTERN_16_23 = 3'd2,
        CFG_PATTERN_24_31 = 3'd3,
        CFG_COMPARE_MASK  = 3'd4,
        CFG_PATTERN_LEN   = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic                       found;
        logic [MatchOffsetBits-1:0] match_offset;
    } result_t;

    typedef struct packed {
        logic range_open;
        logic reported;
    } front_status_t;

endpackage
`default_nettype wire

[hw/rtl/masked_byte_pattern_search_top.sv]
// A result passes from the byte that causes it through the result queue and the output register to out_valid.
// Throughput: one byte per cycle while in_stall is low; the shift-and compare of the full pattern is combinational.
// A two-entry result queue and the output register let input and output stall independently.
// Reset (rst_n, async, active low): clears the range state and the queue, pattern
// registers and mask to zero, and pattern length to one.
`default_nettype none
module masked_byte_pattern_search_top
    import mbps_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [CfgIndexBits-1:0]     cfg_index,
    input  wire logic [CfgDataBits-1:0]      cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [7:0]                  data_byte,
    input  wire logic                        last_in_range,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             found,
    output logic [MatchOffsetBits-1:0]       match_offset
);

    logic                     push;
    result_t                  push_data;
    front_status_t            status;
    logic                     pop;
    result_t                  pop_data;
    logic                     fifo_not_empty;
    logic                     fifo_full;
    logic [FifoCountBits-1:0] fifo_count;

    assign in_stall = fifo_full;

    mbps_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .last_in_range (last_in_range),
        .push          (push),
        .push_data     (push_data),
        .status        (status)
    );

    mbps_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (fifo_not_empty),
        .full      (fifo_full),
        .count     (fifo_count)
    );

    mbps_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .fifo_valid   (fifo_not_empty),
        .fifo_data    (pop_data),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .match_offset (match_offset)
    );

    a_not_found_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> match_offset == '0)
        else $error("not-found transaction with nonzero offset");

    a_last_clears_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_in_range |=> !status.range_open && !status.reported)
        else $error("range state not cleared after final byte");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_full |-> !push)
        else $error("result pushed into full queue");

    a_push_raises_count: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> fifo_count == $past(fifo_count) + FifoCountBits'(1))
        else $error("queued result lost");

endmodule
`default_nettype wire

[hw/rtl/mbps_fifo.sv]
`default_nettype none
module mbps_fifo
    import mbps_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire result_t                  push_data,
    input  wire logic                     pop,
    output result_t                       pop_data,
    output logic                          not_empty,
    output logic                          full,
    output logic [FifoCountBits-1:0]      count
);

    result_t                  entry_reg [FifoDepth];
    logic [FifoPtrBits-1:0]   wr_ptr_reg;
    logic [FifoPtrBits-1:0]   wr_ptr_next;
    logic [FifoPtrBits-1:0]   rd_ptr_reg;
    logic [FifoPtrBits-1:0]   rd_ptr_next;
    logic [FifoCountBits-1:0] count_reg;
    logic [FifoCountBits-1:0] count_next;
    logic                     do_push;
    logic                     do_pop;

    assign full      = (count_reg == FifoCountBits'(FifoDepth));
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == FifoPtrBits'(FifoDepth - 1)) ? '0
                          : wr_ptr_reg + FifoPtrBits'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FifoPtrBits'(FifoDepth - 1)) ? '0
                          : rd_ptr_reg + FifoPtrBits'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + FifoCountBits'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - FifoCountBits'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/mbps_front.sv]
`default_nettype none
module mbps_front
    import mbps_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CfgIndexBits-1:0] cfg_index,
    input  wire logic [CfgDataBits-1:0]  cfg_data,
    input  wire logic                    in_valid,
    input  wire logic                    in_stall,
    input  wire logic [7:0]              data_byte,
    input  wire logic                    last_in_range,
    output logic                         push,
    output result_t                      push_data,
    output front_status_t                status
);

    logic [CfgDataBits-1:0]     pat0_reg;
    logic [CfgDataBits-1:0]     pat1_reg;
    logic [CfgDataBits-1:0]     pat2_reg;
    logic [CfgDataBits-1:0]     pat3_reg;
    logic [MaskBits-1:0]        mask_reg;
    logic [LenBits-1:0]         len_cfg_reg;

    logic [MaxPatternBytes-1:0] hit_reg;
    logic [MaxPatternBytes-1:0] hit_next;
    logic [OffsetBits-1:0]      cnt_reg;
    logic [OffsetBits-1:0]      cnt_next;
    logic                       reported_reg;
    logic                       reported_next;

    logic [8*MaxPatternBytes-1:0] pattern;
    logic [MaxPatternBytes-1:0]   eq_vec;
    logic [MaxPatternBytes-1:0]   hit_shift;
    logic [LenBits-1:0]           len_used;
    logic [LenBits-1:0]           len_m1;
    logic [OffsetBits-1:0]        cnt_inc;
    logic                         matched;
    logic                         accept;

    assign pattern = {pat3_reg, pat2_reg, pat1_reg, pat0_reg};
    assign accept  = in_valid && !in_stall;

    always_comb
    begin
        if (len_cfg_reg == '0)
        begin
            len_used = LenBits'(1);
        end
        else if (len_cfg_reg > LenBits'(MaxPatternBytes))
        begin
            len_used = LenBits'(MaxPatternBytes);
        end
        else
        begin
            len_used = len_cfg_reg;
        end
        len_m1 = len_used - LenBits'(1);
    end

    always_comb
    begin
        for (int i = 0; i < MaxPatternBytes; i++)
        begin
            eq_vec[i] = !mask_reg[i] || (pattern[i*8 +: 8] == data_byte);
        end
    end

    // each bit tracks a live partial match of the pattern prefix ending here
    assign hit_shift = {hit_reg[MaxPatternBytes-2:0], 1'b1} & eq_vec;
    assign matched   = hit_shift[len_m1[LenIdxBits-1:0]];
    assign cnt_inc   = (cnt_reg == '1) ? cnt_reg : cnt_reg + OffsetBits'(1);

    always_comb
    begin
        push                   = accept && !reported_reg && (matched || last_in_range);
        push_data.found        = matched;
        push_data.match_offset = matched
            ? MatchOffsetBits'(cnt_inc - OffsetBits'(len_used)) : '0;
    end

    always_comb
    begin
        hit_next      = hit_reg;
        cnt_next      = cnt_reg;
        reported_next = reported_reg;
        if (accept)
        begin
            if (last_in_range)
            begin
                hit_next      = '0;
                cnt_next      = '0;
                reported_next = 1'b0;
            end
            else
            begin
                hit_next      = hit_shift;
                cnt_next      = cnt_inc;
                reported_next = reported_reg || matched;
            end
        end
    end

    assign status.range_open = (cnt_reg != '0);
    assign status.reported   = reported_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat0_reg     <= '0;
            pat1_reg     <= '0;
            pat2_reg     <= '0;
            pat3_reg     <= '0;
            mask_reg     <= '0;
            len_cfg_reg  <= LenBits'(1);
            hit_reg      <= '0;
            cnt_reg      <= '0;
            reported_reg <= 1'b0;
        end
        else
        begin
            hit_reg      <= hit_next;
            cnt_reg      <= cnt_next;
            reported_reg <= reported_next;
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_PATTERN_0_7:   pat0_reg    <= cfg_data;
                    CFG_PATTERN_8_15:  pat1_reg    <= cfg_data;
                    CFG_PATTERN_16_23: pat2_reg    <= cfg_data;
                    CFG_PATTERN_24_31: pat3_reg    <= cfg_data;
                    CFG_COMPARE_MASK:  mask_reg    <= cfg_data[MaskBits-1:0];
                    CFG_PATTERN_LEN:   len_cfg_reg <= cfg_data[LenBits-1:0];
                    default:           ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

[hw/rtl/mbps_back.sv]
`default_nettype none
module mbps_back
    import mbps_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        fifo_valid,
    input  wire result_t                     fifo_data,
    output logic                             pop,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             found,
    output logic [MatchOffsetBits-1:0]       match_offset
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;

    assign pop = fifo_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // load only on a completed handoff so a stalled transaction holds
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= fifo_data;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = out_data_reg.found;
    assign match_offset = out_data_reg.match_offset;

endmodule
`default_nettype wire

[sim/masked_byte_pattern_search_top_tb.sv]
module masked_byte_pattern_search_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mbps_pkg::*;

    localparam logic [7:0] WildcardChar = 8'h3F;
    localparam logic [CfgIndexBits-1:0] CfgIndexSpareA = 3'd6;
    localparam logic [CfgIndexBits-1:0] CfgIndexSpareB = 3'd7;
    localparam cfg_index_t PatternWordIndex [4] = '{
        CFG_PATTERN_0_7, CFG_PATTERN_8_15, CFG_PATTERN_16_23, CFG_PATTERN_24_31
    };
    localparam int SettleCycles  = 8;
    localparam int HoldOffCycles = 400;
    localparam int RandomGoal    = 420;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CfgIndexBits-1:0]    cfg_index;
    logic [CfgDataBits-1:0]     cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic [7:0]                 data_byte;
    logic                       last_in_range;
    logic                       out_valid;
    logic                       out_stall;
    logic                       found;
    logic [MatchOffsetBits-1:0] match_offset;

    logic [63:0]           pat_word [4];
    logic [MaskBits-1:0]   pat_mask;
    logic [LenBits-1:0]    pat_len_reg;
    logic [7:0]            scan_window [MaxPatternBytes];
    logic [OffsetBits-1:0] scan_count;
    logic                  scan_reported;
    result_t               results_due [$];

    int error_count  = 0;
    int bytes_sent   = 0;
    int idle_pct     = 0;
    int stall_pct    = 0;
    int hold_request = 0;

    masked_byte_pattern_search_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .last_in_range (last_in_range),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .match_offset  (match_offset)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [7:0] pattern_byte_at(int unsigned pos);
        return pat_word[pos / 8][(pos % 8) * 8 +: 8];
    endfunction

    function automatic int unsigned active_length();
        int unsigned len;
        len = pat_len_reg;
        if (len == 0)
            len = 1;
        if (len > MaxPatternBytes)
            len = MaxPatternBytes;
        return len;
    endfunction

    function automatic logic [7:0] alphabet_byte();
        case ($urandom_range(3))
            0: return 8'h00;
            1: return 8'hFF;
            2: return WildcardChar;
            default: return 8'h41;
        endcase
    endfunction

    function automatic logic [7:0] filler_byte();
        case ($urandom_range(3))
            0: return alphabet_byte();
            1: return pattern_byte_at($urandom_range(MaxPatternBytes - 1));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic clear_scan();
        foreach (scan_window[k])
            scan_window[k] = 8'h00;
        scan_count = '0;
        scan_reported = 1'b0;
    endtask

    task automatic predict_search(input logic [7:0] value, input logic is_last);
        int unsigned len;
        logic hit;
        result_t res;
        len = active_length();
        for (int k = MaxPatternBytes - 1; k > 0; k--)
            scan_window[k] = scan_window[k - 1];
        scan_window[0] = value;
        if (scan_count != '1)
            scan_count = scan_count + 1'b1;
        if (!scan_reported && scan_count >= len)
        begin
            hit = 1'b1;
            for (int unsigned i = 0; i < len; i++)
                if (pat_mask[i] && scan_window[len - 1 - i] != pattern_byte_at(i))
                    hit = 1'b0;
            if (hit)
            begin
                res.found = 1'b1;
                res.match_offset = MatchOffsetBits'(scan_count - OffsetBits'(len));
                results_due.push_back(res);
                scan_reported = 1'b1;
            end
        end
        if (is_last)
        begin
            if (!scan_reported)
            begin
                res.found = 1'b0;
                res.match_offset = '0;
                results_due.push_back(res);
            end
            clear_scan();
        end
    endtask

    task automatic write_reg(input logic [CfgIndexBits-1:0] index,
                             input logic [CfgDataBits-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (index)
            CFG_PATTERN_0_7:   pat_word[0] = value;
            CFG_PATTERN_8_15:  pat_word[1] = value;
            CFG_PATTERN_16_23: pat_word[2] = value;
            CFG_PATTERN_24_31: pat_word[3] = value;
            CFG_COMPARE_MASK:  pat_mask = value[MaskBits-1:0];
            CFG_PATTERN_LEN:   pat_len_reg = value[LenBits-1:0];
            default: ;
        endcase
    endtask

    task automatic send_byte(input logic [7:0] value, input logic is_last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= value;
        last_in_range <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_search(value, is_last);
        bytes_sent++;
    endtask

    task automatic send_range(input logic [7:0] range_bytes [$]);
        foreach (range_bytes[k])
            send_byte(range_bytes[k], k == range_bytes.size() - 1);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_random_config();
        logic [CfgDataBits-1:0] word;
        logic [LenBits-1:0] len;
        foreach (PatternWordIndex[w])
        begin
            case ($urandom_range(3))
                0: word = '0;
                1: word = '1;
                2:
                begin
                    for (int b = 0; b < 8; b++)
                        word[b * 8 +: 8] = alphabet_byte();
                end
                default: word = {$urandom, $urandom};
            endcase
            write_reg(PatternWordIndex[w], word);
        end
        case ($urandom_range(3))
            0: word = '1;
            1: word = '0;
            2: word = {$urandom, $urandom & $urandom};
            default: word = {$urandom, $urandom};
        endcase
        write_reg(CFG_COMPARE_MASK, word);
        case ($urandom_range(9))
            0: len = 6'd0;
            1: len = 6'd63;
            2: len = 6'($urandom_range(33, 62));
            3: len = 6'd32;
            4: len = 6'd1;
            5, 6: len = 6'($urandom_range(9, 31));
            default: len = 6'($urandom_range(1, 8));
        endcase
        write_reg(CFG_PATTERN_LEN, {$urandom, 26'($urandom), len});
        if ($urandom_range(3) == 0)
            write_reg($urandom_range(1) ? CfgIndexSpareA : CfgIndexSpareB, {$urandom, $urandom});
    endtask

    task automatic send_random_range();
        logic [7:0] range_bytes [$];
        int unsigned len;
        int unsigned kind;
        int unsigned lead;
        int unsigned pos;
        len = active_length();
        kind = $urandom_range(99);
        if (kind < 70)
        begin
            lead = $urandom_range(0, 6);
            repeat (lead) range_bytes.push_back(filler_byte());
            for (int unsigned i = 0; i < len; i++)
                range_bytes.push_back(pat_mask[i] ? pattern_byte_at(i) : filler_byte());
            if (kind < 12)
            begin
                pos = lead + $urandom_range(0, len - 1);
                range_bytes[pos] = range_bytes[pos] ^ (8'd1 << $urandom_range(7));
            end
            repeat ($urandom_range(0, 6)) range_bytes.push_back(filler_byte());
        end
        else
        begin
            repeat ($urandom_range(1, 40)) range_bytes.push_back(filler_byte());
        end
        send_range(range_bytes);
    endtask

    task automatic test_reset_defaults();
        idle_pct = 0;
        stall_pct = 0;
        send_range('{8'h00, 8'hFF});
        drain_results();
    endtask

    task automatic test_match_placement();
        write_reg(CFG_PATTERN_0_7, {40'h0, 8'hFF, WildcardChar, 8'hAA});
        write_reg(CFG_PATTERN_8_15, '0);
        write_reg(CFG_PATTERN_16_23, '0);
        write_reg(CFG_PATTERN_24_31, '0);
        write_reg(CFG_COMPARE_MASK, 64'h5);
        write_reg(CFG_PATTERN_LEN, 64'd3);
        send_range('{8'hAA, WildcardChar});
        send_range('{8'h00, 8'hAA, 8'h12, 8'hFF});
        send_range('{8'hAA, WildcardChar, 8'hFF, 8'hAA, 8'h00, 8'hFF});
        drain_results();
    endtask

    task automatic test_zero_length();
        write_reg(CFG_PATTERN_LEN, 64'd0);
        send_range('{8'h55, 8'hAA, 8'h01});
        drain_results();
    endtask

    task automatic test_spare_register_index();
        write_reg(CfgIndexSpareA, '1);
        write_reg(CfgIndexSpareB, '1);
        send_range('{8'h55, 8'hAA});
        drain_results();
    endtask

    task automatic test_output_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        write_reg(CFG_COMPARE_MASK, '0);
        write_reg(CFG_PATTERN_LEN, 64'd1);
        hold_request = HoldOffCycles;
        repeat (20) send_range('{8'($urandom_range(255)), 8'($urandom_range(255))});
        drain_results();
    endtask

    task automatic test_random_ranges(input int send_idle, input int recv_stall,
                                      input int item_goal);
        int stop_at;
        idle_pct = send_idle;
        stall_pct = recv_stall;
        stop_at = bytes_sent + item_goal;
        while (bytes_sent < stop_at)
        begin
            write_random_config();
            repeat ($urandom_range(3, 8)) send_random_range();
            drain_results();
        end
    endtask

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t: unexpected result, found=%0b match_offset=%0d",
                         $time, found, match_offset);
                error_count++;
            end
            else
            begin
                want = results_due.pop_front();
                if (found !== want.found)
                begin
                    $display("%0t: found expected %0b actual %0b", $time, want.found, found);
                    error_count++;
                end
                if (match_offset !== want.match_offset)
                begin
                    $display("%0t: match_offset expected %0d actual %0d",
                             $time, want.match_offset, match_offset);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        data_byte = '0;
        last_in_range = 1'b0;
        foreach (pat_word[w])
            pat_word[w] = '0;
        pat_mask = '0;
        pat_len_reg = 6'd1;
        clear_scan();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_match_placement();
        test_zero_length();
        test_spare_register_index();
        test_output_backpressure();
        test_random_ranges(0, 0, RandomGoal);
        test_random_ranges(88, 0, RandomGoal);
        test_random_ranges(0, 88, RandomGoal);
        test_random_ranges(11, 11, RandomGoal);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
